// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== rtl/gpd_pkg.sv =====
`default_nettype none

package gpd_pkg;

  // field widths
  localparam int AngW  = 32;
  localparam int AltW  = 28;
  localparam int RadW  = 33;
  localparam int DistW = 34;

  // datapath word, multiplier halves, square root digits
  localparam int VW = 48;
  localparam int HW = VW / 2;
  localparam int SqrtBits = VW;

  localparam int CordicStagesDef = 24;

  // pipeline depths
  localparam int MulLat   = 4;
  localparam int PlaceLat = 2 * MulLat;
  localparam int DistLat  = MulLat + 1 + SqrtBits + 1;
  localparam int LaneFix  = 4;

  // angles in degrees Q8.23
  localparam logic signed [AngW:0] DegHalf    = 33'sd1509949440;
  localparam logic signed [AngW:0] DegQuarter = 33'sd754974720;
  localparam logic signed [AngW:0] DegTurn    = 33'sd3019898880;

  localparam logic [RadW-1:0]  RadiusReset = 33'd6378137000;
  localparam logic [DistW-1:0] DistMax     = '1;

  // pi/180 in Q38
  localparam real PiR = 4.0 * $atan(1.0);
  localparam logic [32:0] Deg2RadQ38 = 33'(longint'(PiR / 180.0 * (2.0 ** 38)));

  // atan(2^-i) in radians Q40
  function automatic longint atan_q40(input int i);
    return longint'($atan(2.0 ** (-i)) * (2.0 ** 40));
  endfunction

  // CORDIC gain squared over n stages
  function automatic real cordic_gain_sq(input int n);
    real p;
    p = 1.0;
    for (int k = 0; k < n; k++) begin
      p = p * (1.0 + 2.0 ** (-2 * k));
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gpd_sincos_lane.sv =====
`default_nettype none

// One lane: angle reduction, degree to radian scaling and a pipelined
// rotation CORDIC giving sin and cos in Q40.
module gpd_sincos_lane #(
  parameter int STAGES = gpd_pkg::CordicStagesDef
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [gpd_pkg::AngW-1:0]  angle_i,
  output logic signed [gpd_pkg::VW-1:0]    sin_o,
  output logic signed [gpd_pkg::VW-1:0]    cos_o
);
  import gpd_pkg::*;

  localparam real GainSq = cordic_gain_sq(STAGES);
  localparam logic signed [VW-1:0] X0 = VW'(longint'((2.0 ** 40) / $sqrt(GainSq)));

  logic signed [AngW:0] d0_c, d1_c, d2_c, d3_c;
  logic                 fold_c;
  logic signed [30:0]   ang_a_r;
  logic                 flip_a_r;
  logic [29:0]          mag_c;
  logic [62:0]          prod_b_r;
  logic                 neg_b_r, flip_b_r;
  logic [41:0]          zm_c;

  logic signed [VW-1:0] x_r [0:STAGES];
  logic signed [VW-1:0] y_r [0:STAGES];
  logic signed [VW-1:0] z_r [0:STAGES];
  logic                 flip_r [0:STAGES];
  logic signed [VW-1:0] sin_r, cos_r;

  // wrap into (-180, 180], fold into [-90, 90]
  always_comb begin
    d0_c = (AngW+1)'(angle_i);
    d1_c = (d0_c > DegHalf) ? d0_c - DegTurn : d0_c;
    d2_c = (d1_c <= -DegHalf) ? d1_c + DegTurn : d1_c;
    fold_c = 1'b1;
    if (d2_c > DegQuarter) begin
      d3_c = DegHalf - d2_c;
    end else if (d2_c < -DegQuarter) begin
      d3_c = -DegHalf - d2_c;
    end else begin
      d3_c = d2_c;
      fold_c = 1'b0;
    end
  end

  always_comb begin
    mag_c = ang_a_r[30] ? 30'(-ang_a_r) : 30'(ang_a_r);
    zm_c  = 42'((prod_b_r + (63'd1 << 20)) >> 21);
  end

  // reduction, scaling, rounding to Q40
  always_ff @(posedge clk) begin
    if (en) begin
      ang_a_r  <= d3_c[30:0];
      flip_a_r <= fold_c;
      prod_b_r <= 63'(mag_c) * 63'(Deg2RadQ38);
      neg_b_r  <= ang_a_r[30];
      flip_b_r <= flip_a_r;
      x_r[0]   <= X0;
      y_r[0]   <= '0;
      z_r[0]   <= neg_b_r ? -$signed({6'b0, zm_c}) : $signed({6'b0, zm_c});
      flip_r[0] <= flip_b_r;
    end
  end

  // rotation stages
  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam logic signed [VW-1:0] AtanK = VW'(atan_q40(k));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[k][VW-1]) begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - AtanK;
        end else begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + AtanK;
        end
        flip_r[k+1] <= flip_r[k];
      end
    end
  end

  // cosine negated where the angle was folded
  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= y_r[STAGES];
      cos_r <= flip_r[STAGES] ? -x_r[STAGES] : x_r[STAGES];
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

`default_nettype wire

// ===== rtl/gpd_mulq.sv =====
`default_nettype none

// Signed multiply, shifted right by SH with rounding half away from zero.
// Four 24x24 partial products; stages: magnitudes, products, cross terms, result.
module gpd_mulq #(
  parameter int SH = 0
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [gpd_pkg::VW-1:0]     a_i,
  input  logic signed [gpd_pkg::VW-1:0]     b_i,
  output logic signed [2*gpd_pkg::VW-1:0]   p_o
);
  import gpd_pkg::*;

  localparam int PW = 2 * VW;
  localparam logic [PW-1:0] Rnd = (PW'(1) << SH) >> 1;

  logic          neg1_r, neg2_r, neg3_r;
  logic [VW-1:0] ua_r, ub_r;
  logic [VW-1:0] p00_r, p01_r, p10_r, p11_r;
  logic [VW:0]   mid_r;
  logic [PW-1:0] hl_r;
  logic [PW-1:0] full_c, mag_c;
  logic signed [PW-1:0] p_r;

  always_comb begin
    full_c = hl_r + (PW'(mid_r) << HW) + Rnd;
    mag_c  = full_c >> SH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitudes
      neg1_r <= a_i[VW-1] ^ b_i[VW-1];
      ua_r   <= a_i[VW-1] ? -a_i : a_i;
      ub_r   <= b_i[VW-1] ? -b_i : b_i;
      // partial products
      neg2_r <= neg1_r;
      p00_r  <= ua_r[HW-1:0]  * ub_r[HW-1:0];
      p01_r  <= ua_r[HW-1:0]  * ub_r[VW-1:HW];
      p10_r  <= ua_r[VW-1:HW] * ub_r[HW-1:0];
      p11_r  <= ua_r[VW-1:HW] * ub_r[VW-1:HW];
      // cross terms
      neg3_r <= neg2_r;
      mid_r  <= (VW+1)'(p01_r) + (VW+1)'(p10_r);
      hl_r   <= {p11_r, p00_r};
      // round, shift, sign
      p_r    <= neg3_r ? -$signed(mag_c) : $signed(mag_c);
    end
  end

  assign p_o = p_r;

endmodule

`default_nettype wire

// ===== rtl/gpd_place.sv =====
`default_nettype none

// Places one point on the sphere in mm Q8 coordinates.
module gpd_place (
  input  logic                            clk,
  input  logic                            en,
  input  logic [gpd_pkg::RadW-1:0]        radius_i,
  input  logic signed [gpd_pkg::AltW-1:0] alt_i,
  input  logic signed [gpd_pkg::VW-1:0]   so_i,
  input  logic signed [gpd_pkg::VW-1:0]   co_i,
  input  logic signed [gpd_pkg::VW-1:0]   sl_i,
  input  logic signed [gpd_pkg::VW-1:0]   cl_i,
  output logic signed [gpd_pkg::VW-1:0]   px_o,
  output logic signed [gpd_pkg::VW-1:0]   py_o,
  output logic signed [gpd_pkg::VW-1:0]   pz_o
);
  import gpd_pkg::*;

  logic signed [VW-1:0]   r_c;
  logic signed [2*VW-1:0] rc_w, ry_w, px_w, pz_w;
  logic signed [VW-1:0]   so_d_r [0:MulLat-1];
  logic signed [VW-1:0]   co_d_r [0:MulLat-1];
  logic signed [VW-1:0]   ry_d_r [0:MulLat-1];

  // radius plus altitude, signed
  assign r_c = $signed({{(VW-RadW){1'b0}}, radius_i}) + VW'(alt_i);

  gpd_mulq #(.SH(32)) u_rc (.clk(clk), .en(en), .a_i(r_c), .b_i(cl_i), .p_o(rc_w));
  gpd_mulq #(.SH(32)) u_ry (.clk(clk), .en(en), .a_i(r_c), .b_i(sl_i), .p_o(ry_w));

  // align sines/cosines of longitude with the first products, and y with the second
  always_ff @(posedge clk) begin
    if (en) begin
      so_d_r[0] <= so_i;
      co_d_r[0] <= co_i;
      ry_d_r[0] <= ry_w[VW-1:0];
      for (int i = 1; i < MulLat; i++) begin
        so_d_r[i] <= so_d_r[i-1];
        co_d_r[i] <= co_d_r[i-1];
        ry_d_r[i] <= ry_d_r[i-1];
      end
    end
  end

  gpd_mulq #(.SH(40)) u_px (
    .clk(clk), .en(en), .a_i(rc_w[VW-1:0]), .b_i(so_d_r[MulLat-1]), .p_o(px_w)
  );
  gpd_mulq #(.SH(40)) u_pz (
    .clk(clk), .en(en), .a_i(rc_w[VW-1:0]), .b_i(co_d_r[MulLat-1]), .p_o(pz_w)
  );

  assign px_o = px_w[VW-1:0];
  assign py_o = ry_d_r[MulLat-1];
  assign pz_o = pz_w[VW-1:0];

endmodule

`default_nettype wire

// ===== rtl/gpd_dist.sv =====
`default_nettype none

// Merge stage: coordinate differences, squares, pipelined square root,
// rounding to mm and saturation.
module gpd_dist (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [gpd_pkg::VW-1:0] ax_i,
  input  logic signed [gpd_pkg::VW-1:0] ay_i,
  input  logic signed [gpd_pkg::VW-1:0] az_i,
  input  logic signed [gpd_pkg::VW-1:0] bx_i,
  input  logic signed [gpd_pkg::VW-1:0] by_i,
  input  logic signed [gpd_pkg::VW-1:0] bz_i,
  output logic [gpd_pkg::DistW-1:0]     dist_o
);
  import gpd_pkg::*;

  localparam int PW = 2 * VW;
  localparam int RW = VW + 1;

  logic signed [VW-1:0] dx_c, dy_c, dz_c;
  logic signed [PW-1:0] sx_w, sy_w, sz_w;
  logic [PW-1:0]  rad_r  [0:SqrtBits];
  logic [VW+2:0]  rem_r  [0:SqrtBits];
  logic [VW-1:0]  root_r [0:SqrtBits];
  logic [RW-1:0]  q_c;
  logic [DistW-1:0] dist_r;

  assign dx_c = ax_i - bx_i;
  assign dy_c = ay_i - by_i;
  assign dz_c = az_i - bz_i;

  gpd_mulq #(.SH(0)) u_sx (.clk(clk), .en(en), .a_i(dx_c), .b_i(dx_c), .p_o(sx_w));
  gpd_mulq #(.SH(0)) u_sy (.clk(clk), .en(en), .a_i(dy_c), .b_i(dy_c), .p_o(sy_w));
  gpd_mulq #(.SH(0)) u_sz (.clk(clk), .en(en), .a_i(dz_c), .b_i(dz_c), .p_o(sz_w));

  // sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= $unsigned(sx_w) + $unsigned(sy_w) + $unsigned(sz_w);
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  // one root digit per stage
  for (genvar j = 0; j < SqrtBits; j++) begin : g_sqrt
    logic [VW+2:0] cur_c, trl_c;
    always_comb begin
      cur_c = {rem_r[j][VW:0], rad_r[j][PW-1 -: 2]};
      trl_c = {1'b0, root_r[j], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[j+1] <= rad_r[j] << 2;
        if (cur_c >= trl_c) begin
          rem_r[j+1]  <= cur_c - trl_c;
          root_r[j+1] <= {root_r[j][VW-2:0], 1'b1};
        end else begin
          rem_r[j+1]  <= cur_c;
          root_r[j+1] <= {root_r[j][VW-2:0], 1'b0};
        end
      end
    end
  end

  // Q8 to whole mm, half up, saturate
  assign q_c = ({1'b0, root_r[SqrtBits]} + RW'(128)) >> 8;

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= (q_c > RW'(DistMax)) ? DistMax : q_c[DistW-1:0];
    end
  end

  assign dist_o = dist_r;

endmodule

`default_nettype wire

// ===== rtl/geodetic_point_distance_unit.sv =====
// Straight-line distance between two geodetic points on a sphere.
// Input channel in_*: one transaction carries both points (longitude Q8.23,
// latitude Q7.23, in degrees; altitude in mm). Output channel out_*: one
// transaction per input with the rounded distance in mm, saturated at
// 2^34-1. Config channel cfg_*: writes the sphere radius in mm; always
// ready, to be written only while no transaction is in flight.
// Four sin/cos lanes (one per angle) run side by side, two placement
// units turn them into Cartesian coordinates, and a merge stage forms
// the squared difference and its pipelined square root.
// Pipeline depth is set by the CORDIC depth, the multipliers and the
// bitwise square root. Throughput: one transaction per cycle while
// the output is not held.
// A receiver stall freezes the whole pipeline and holds out_tdata;
// in_tready drops while the output is held.
// Reset clears the valid pipeline and restores the default radius.
`default_nettype none

`include "assert_macros.svh"

module geodetic_point_distance_unit #(
  parameter int CORDIC_STAGES = gpd_pkg::CordicStagesDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // from_lon[31:0] from_lat[62:32] from_alt[90:63]
  // to_lon[122:91] to_lat[153:123] to_alt[181:154], zero pad
  input  logic [183:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // distance_mm[33:0], zero pad
  output logic [39:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [gpd_pkg::RadW-1:0] cfg_data
);
  import gpd_pkg::*;

  localparam int LaneLat = CORDIC_STAGES + LaneFix;
  localparam int TotLat  = LaneLat + PlaceLat + DistLat;

  logic                pipe_en;
  logic [TotLat-1:0]   vld_r;
  logic [RadW-1:0]     radius_r;
  logic signed [AngW-1:0] ang_c [0:3];
  logic signed [VW-1:0]   sin_w [0:3];
  logic signed [VW-1:0]   cos_w [0:3];
  logic signed [AltW-1:0] falt_r [0:LaneLat-1];
  logic signed [AltW-1:0] talt_r [0:LaneLat-1];
  logic signed [VW-1:0]   ax_w, ay_w, az_w, bx_w, by_w, bz_w;
  logic [DistW-1:0]       dist_w;

  // whole pipeline advances unless the output is held
  assign pipe_en    = !out_tvalid || out_tready;
  assign in_tready  = pipe_en;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = vld_r[TotLat-1];
  assign out_tdata  = {{(40-DistW){1'b0}}, dist_w};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      radius_r <= RadiusReset;
    end else begin
      if (pipe_en) begin
        vld_r <= {vld_r[TotLat-2:0], in_tvalid};
      end
      if (cfg_valid) begin
        radius_r <= cfg_data;
      end
    end
  end

  // lane inputs: from lon, from lat, to lon, to lat
  assign ang_c[0] = in_tdata[31:0];
  assign ang_c[1] = {in_tdata[62], in_tdata[62:32]};
  assign ang_c[2] = in_tdata[122:91];
  assign ang_c[3] = {in_tdata[153], in_tdata[153:123]};

  for (genvar g = 0; g < 4; g++) begin : g_lane
    gpd_sincos_lane #(.STAGES(CORDIC_STAGES)) u_lane (
      .clk(clk), .en(pipe_en), .angle_i(ang_c[g]), .sin_o(sin_w[g]), .cos_o(cos_w[g])
    );
  end

  // altitudes ride alongside the lanes
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      falt_r[0] <= in_tdata[90:63];
      talt_r[0] <= in_tdata[181:154];
      for (int i = 1; i < LaneLat; i++) begin
        falt_r[i] <= falt_r[i-1];
        talt_r[i] <= talt_r[i-1];
      end
    end
  end

  gpd_place u_place_a (
    .clk(clk), .en(pipe_en), .radius_i(radius_r), .alt_i(falt_r[LaneLat-1]),
    .so_i(sin_w[0]), .co_i(cos_w[0]), .sl_i(sin_w[1]), .cl_i(cos_w[1]),
    .px_o(ax_w), .py_o(ay_w), .pz_o(az_w)
  );

  gpd_place u_place_b (
    .clk(clk), .en(pipe_en), .radius_i(radius_r), .alt_i(talt_r[LaneLat-1]),
    .so_i(sin_w[2]), .co_i(cos_w[2]), .sl_i(sin_w[3]), .cl_i(cos_w[3]),
    .px_o(bx_w), .py_o(by_w), .pz_o(bz_w)
  );

  gpd_dist u_dist (
    .clk(clk), .en(pipe_en),
    .ax_i(ax_w), .ay_i(ay_w), .az_i(az_w),
    .bx_i(bx_w), .by_i(by_w), .bz_i(bz_w),
    .dist_o(dist_w)
  );

  // valid pipeline freezes on a stall
  `ASSERT_CLK(a_stall_hold, clk, rst_n, !pipe_en |=> $stable(vld_r))
  // last valid stage reaches the output when the pipe moves
  `ASSERT_CLK(a_last_to_out, clk, rst_n, pipe_en && vld_r[TotLat-2] |=> out_tvalid)
  // no new transaction while a result is held
  `ASSERT_NEVER(a_accept_held, clk, rst_n, in_tready && out_tvalid && !out_tready)

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
module tb;
  import gpd_pkg::*;

  localparam int Stages   = CordicStagesDef;
  localparam int SettleCy = 120;
  localparam int HoldCy   = 400;

  // receiver behaviour
  typedef enum int {RxAlways, RxRandom, RxPattern, RxHold} rx_mode_t;

  typedef struct packed {
    logic signed [27:0] to_alt;
    logic signed [30:0] to_lat;
    logic signed [31:0] to_lon;
    logic signed [27:0] from_alt;
    logic signed [30:0] from_lat;
    logic signed [31:0] from_lon;
  } point_pair_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // from_lon, from_lat, from_alt, to_lon, to_lat, to_alt, zero pad
  logic [183:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  // distance_mm, zero pad
  logic [39:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [RadW-1:0] cfg_data;

  geodetic_point_distance_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // predictor constants and configuration
  longint arctan_q40[Stages];
  longint inv_gain_q40;
  longint unsigned deg_to_rad_q38;
  logic [RadW-1:0] radius_mm;

  logic [DistW-1:0] distance_queue[$];
  int errors;
  rx_mode_t rx_mode;
  int hold_count;
  int burst_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // signed (a*b) >> sh, rounded half away from zero
  function automatic longint mul_round(longint a, longint b, int sh);
    logic neg;
    logic [63:0] ua, ub;
    logic [127:0] p;
    logic [62:0] r;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    p = {64'd0, ua} * {64'd0, ub};
    p = p + (128'd1 << (sh - 1));
    r = 63'(p >> sh);
    return neg ? -longint'({1'b0, r}) : longint'({1'b0, r});
  endfunction

  // arctangent of 1/n in Q62 by series
  function automatic longint unsigned arctan_recip(longint unsigned n);
    longint unsigned nn, term, sum, k;
    nn = n * n;
    term = (64'd1 << 62) / n;
    sum = term;
    k = 1;
    while (term != 0) begin
      term = term / nn;
      if (k[0]) sum = sum - term / (2 * k + 1);
      else sum = sum + term / (2 * k + 1);
      k++;
    end
    return sum;
  endfunction

  // arctangent table, degree factor and inverse gain
  task automatic build_constants();
    longint unsigned pi4, p;
    longint y, t;
    pi4 = 4 * arctan_recip(5) - arctan_recip(239);
    arctan_q40[0] = longint'((pi4 + (64'd1 << 21)) >> 22);
    for (int i = 1; i < Stages; i++)
      arctan_q40[i] = longint'((arctan_recip(64'd1 << i) + (64'd1 << 21)) >> 22);
    deg_to_rad_q38 = (pi4 / 45 + (64'd1 << 23)) >> 24;
    p = 64'd1 << 60;
    for (int i = 0; i < Stages; i++) p = p + (p >> (2 * i));
    y = longint'(3) << 58;
    for (int i = 0; i < 12; i++) begin
      t = mul_round(y, y, 60);
      t = mul_round(longint'(p), t, 60);
      y = mul_round(y, (longint'(3) << 60) - t, 61);
    end
    inv_gain_q40 = (y + (longint'(1) << 19)) >>> 20;
  endtask

  // sine and cosine in Q40 of a Q8.23 degree angle
  task automatic sin_cos(input longint deg, output longint s, output longint c);
    logic flip, neg;
    longint unsigned mag;
    longint x, y, z, dx, dy;
    flip = 1'b0;
    if (deg > longint'(DegHalf)) deg -= longint'(DegTurn);
    if (deg <= -longint'(DegHalf)) deg += longint'(DegTurn);
    if (deg > longint'(DegQuarter)) begin
      deg = longint'(DegHalf) - deg;
      flip = 1'b1;
    end else if (deg < -longint'(DegQuarter)) begin
      deg = -longint'(DegHalf) - deg;
      flip = 1'b1;
    end
    neg = deg < 0;
    mag = neg ? 64'(-deg) : 64'(deg);
    z = longint'((mag * deg_to_rad_q38 + (64'd1 << 20)) >> 21);
    if (neg) z = -z;
    x = inv_gain_q40;
    y = 0;
    for (int i = 0; i < Stages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q40[i];
      end else begin
        x += dx; y -= dy; z += arctan_q40[i];
      end
    end
    s = y;
    c = flip ? -x : x;
  endtask

  // Cartesian position in mm Q8
  task automatic place_point(input longint lon, input longint lat, input longint alt,
                             output longint px, output longint py, output longint pz);
    longint so, co, sl, cl, r, rc;
    sin_cos(lon, so, co);
    sin_cos(lat, sl, cl);
    r = longint'({31'd0, radius_mm}) + alt;
    rc = mul_round(r, cl, 32);
    px = mul_round(rc, so, 40);
    py = mul_round(r, sl, 32);
    pz = mul_round(rc, co, 40);
  endtask

  task automatic predict_distance(input point_pair_t pp, output logic [DistW-1:0] dist_exp);
    longint a[3], b[3], d;
    logic [63:0] ud;
    logic [127:0] sum, cc;
    logic [63:0] root, cand, q;
    place_point(longint'(pp.from_lon), longint'(pp.from_lat), longint'(pp.from_alt),
                a[0], a[1], a[2]);
    place_point(longint'(pp.to_lon), longint'(pp.to_lat), longint'(pp.to_alt),
                b[0], b[1], b[2]);
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      d = a[i] - b[i];
      ud = (d < 0) ? 64'(-d) : 64'(d);
      sum = sum + {64'd0, ud} * {64'd0, ud};
    end
    root = '0;
    for (int i = 47; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      cc = {64'd0, cand} * {64'd0, cand};
      if (cc <= sum) root = cand;
    end
    q = (root + 128) >> 8;
    dist_exp = (q > 64'(DistMax)) ? DistMax : q[DistW-1:0];
  endtask

  // receiver stall pattern, long hold counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_count <= 0;
    end else if (rx_mode == RxHold && hold_count < HoldCy) begin
      out_tready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      if (rx_mode != RxHold) hold_count <= 0;
      case (rx_mode)
        RxRandom:  out_tready <= ($urandom_range(0, 99) < 65);
        RxPattern: out_tready <= (($urandom_range(0, 0) + hold_count + $time / 10) % 7 < 4);
        default:   out_tready <= 1'b1;
      endcase
    end
  end

  // result check against oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (distance_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time,
                 out_tdata[DistW-1:0]);
        errors++;
      end else begin
        if (out_tdata[DistW-1:0] !== distance_queue[0]) begin
          $display("%0t: distance_mm mismatch, expected %0d, actual %0d", $time,
                   distance_queue[0], out_tdata[DistW-1:0]);
          errors++;
        end
        void'(distance_queue.pop_front());
      end
    end
  end

  // one transaction on the input channel; idle afterwards for the given gap
  task automatic send_pair(input point_pair_t pp, input int gap);
    logic [DistW-1:0] dist_exp;
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, pp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_distance(pp, dist_exp);
    distance_queue.push_back(dist_exp);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // bursts of random length with random gaps, back to back when idle_ok is clear
  task automatic send_bursty(input point_pair_t pp, input bit idle_ok);
    int gap;
    gap = 0;
    if (idle_ok) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 6);
      end else burst_left--;
    end
    send_pair(pp, gap);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (distance_queue.size() != 0) @(posedge clk);
    repeat (SettleCy) @(posedge clk);
  endtask

  task automatic write_radius(input logic [RadW-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    radius_mm = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic longint rand_lon(bit full);
    if (full) return longint'($signed($urandom));
    return longint'($urandom_range(0, 32'd3019898880)) - 64'd1509949440;
  endfunction

  function automatic longint rand_lat(bit full);
    if (full) return longint'($signed($urandom)) >>> 1;
    return longint'($urandom_range(0, 32'd1509949440)) - 64'd754974720;
  endfunction

  function automatic longint rand_alt(bit full);
    if (full) return longint'($signed($urandom)) >>> 4;
    return longint'($urandom_range(0, 120000000)) - 64'd20000000;
  endfunction

  // mostly plausible track pairs, some near neighbours, some full-width noise
  function automatic point_pair_t random_pair();
    point_pair_t pp;
    int kind;
    bit full;
    kind = $urandom_range(0, 9);
    full = (kind >= 8);
    pp.from_lon = 32'(rand_lon(full));
    pp.from_lat = 31'(rand_lat(full));
    pp.from_alt = 28'(rand_alt(full));
    if (kind < 4) begin
      pp.to_lon = pp.from_lon + 32'($signed($urandom_range(0, 2000000)) - 1000000);
      pp.to_lat = pp.from_lat + 31'($signed($urandom_range(0, 2000000)) - 1000000);
      pp.to_alt = pp.from_alt + 28'($signed($urandom_range(0, 20000)) - 10000);
    end else begin
      pp.to_lon = 32'(rand_lon(full));
      pp.to_lat = 31'(rand_lat(full));
      pp.to_alt = 28'(rand_alt(full));
    end
    return pp;
  endfunction

  function automatic point_pair_t make_pair(longint flon, longint flat, longint falt,
                                            longint tlon, longint tlat, longint talt);
    point_pair_t pp;
    pp.from_lon = 32'(flon);
    pp.from_lat = 31'(flat);
    pp.from_alt = 28'(falt);
    pp.to_lon = 32'(tlon);
    pp.to_lat = 31'(tlat);
    pp.to_alt = 28'(talt);
    return pp;
  endfunction

  // field extremes, poles, wrap, fold, antipodes
  task automatic test_directed();
    longint h, q;
    h = longint'(DegHalf);
    q = longint'(DegQuarter);
    send_pair(make_pair(0, 0, 0, 0, 0, 0), 0);
    send_pair(make_pair(h, 0, 0, -h, 0, 0), 0);
    send_pair(make_pair(0, q, 0, 0, -q, 0), 1);
    send_pair(make_pair(0, 0, 0, h, 0, 0), 0);
    send_pair(make_pair(0, 0, -20000000, 0, 0, 100000000), 0);
    send_pair(make_pair(h + 1, 0, 0, -h, 0, 0), 2);
    send_pair(make_pair(-h - 1, 1, 0, h, -1, 0), 0);
    send_pair(make_pair(2147483647, 1073741823, 134217727,
                        -2147483648, -1073741824, -134217728), 0);
    send_pair(make_pair(1000, 1000000000, 0, 1000, -1000000000, 0), 0);
    send_pair(make_pair(q + 1, q, 5, -q - 1, -q, 7), 3);
    send_pair(make_pair(1, 1, 1, 1, 1, 1), 0);
    send_pair(make_pair(0, 0, 0, 1, 0, 0), 0);
    send_pair(make_pair(-1, -1, -1, 0, 0, 0), 0);
    send_pair(make_pair(123456789, -98765432, 8848000, -55555555, 333333333, -10994000), 0);
  endtask

  task automatic test_radius_extremes();
    longint h;
    h = longint'(DegHalf);
    write_radius(33'd1000000);
    // negative radius once the altitude is added
    send_pair(make_pair(0, 0, -20000000, h, 0, -20000000), 0);
    send_pair(make_pair(0, 0, -1000000, 0, 0, 100000000), 0);
    send_pair(make_pair(7, 9, 0, 11, 13, 0), 0);
    write_radius(33'h1_FFFF_FFFF);
    // beyond the result range: saturates
    send_pair(make_pair(0, 0, 100000000, h, 0, 100000000), 0);
    send_pair(make_pair(0, 754974720, 134217727, 0, -754974720, 134217727), 0);
    send_pair(make_pair(0, 0, 0, 3, 0, 0), 0);
  endtask

  task automatic test_random_phases(input int per_phase);
    logic [RadW-1:0] radii[4];
    radii[0] = RadiusReset;
    radii[1] = {1'($urandom_range(0, 1)), $urandom} | 33'd1000000;
    radii[2] = 33'd1000000 + $urandom_range(0, 5000000);
    radii[3] = 33'h1_FFFF_FFFF;
    for (int ph = 0; ph < 4; ph++) begin
      write_radius(radii[ph]);
      rx_mode = (ph % 2 == 0) ? RxRandom : RxPattern;
      burst_left = 0;
      for (int n = 0; n < per_phase; n++)
        send_bursty(random_pair(), (n / 60) % 3 != 2);
    end
  endtask

  // receiver holds off long enough for the pipeline to fill and stall input
  task automatic test_backpressure();
    drain();
    rx_mode = RxHold;
    for (int n = 0; n < 150; n++) send_pair(random_pair(), 0);
    drain();
    rx_mode = RxAlways;
    for (int n = 0; n < 40; n++) send_pair(random_pair(), 0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    burst_left = 0;
    rx_mode = RxAlways;
    radius_mm = RadiusReset;
    build_constants();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_radius_extremes();
    test_random_phases(150);
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
